### sv/bba_pkg.sv
// shared types and constants of the buddy bitmap allocator
`default_nettype none
package bba_pkg;

    localparam int CMD_W   = 1;
    localparam int SIZE_W  = 32;
    localparam int BIDX_W  = 10;
    localparam int LV_W    = 4;
    localparam int MBS_W   = 21;
    localparam int OFF_W   = 29;
    localparam int TSIZE_W = SIZE_W + 1;
    localparam int HEADER_BYTES = 8;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_SIZE    = 3'd1,
        ST_TOO_LARGE   = 3'd2,
        ST_NO_BLOCK    = 3'd3,
        ST_DOUBLE_FREE = 3'd4,
        ST_BAD_INDEX   = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TREE_LEVELS = 1'b0,
        REG_MIN_BUCKET  = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_CHECK,
        FSM_LEVEL,
        FSM_SCAN_RD,
        FSM_SCAN_CHK,
        FSM_FREE_CHK,
        FSM_SUB,
        FSM_UP,
        FSM_MERGE_RD,
        FSM_MERGE_CHK,
        FSM_DONE
    } fsm_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } lvl_ctl_t;

endpackage
`default_nettype wire

### sv/bba_req_if.sv
// request channel of the buddy bitmap allocator
`default_nettype none
interface bba_req_if;
    import bba_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      command;
    logic signed [SIZE_W-1:0]  request_size;
    logic [BIDX_W-1:0]         block_index;

    modport source (output valid, command, request_size, block_index, input ready);
    modport sink (input valid, command, request_size, block_index, output ready);
endinterface
`default_nettype wire

### sv/bba_rsp_if.sv
// response channel of the buddy bitmap allocator
`default_nettype none
interface bba_rsp_if;
    import bba_pkg::*;

    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [BIDX_W-1:0]  node_index;
    logic [LV_W-1:0]    node_level;
    logic [OFF_W-1:0]   block_offset;

    modport source (output valid, status, node_index, node_level, block_offset, input ready);
    modport sink (input valid, status, node_index, node_level, block_offset, output ready);
endinterface
`default_nettype wire

### sv/buddy_bitmap_allocator_unit.sv
// top level of the buddy bitmap allocator: sequencer, configuration and result register
//
//  channel | dir | handshake     | payload
//  req     | in  | valid/ready   | command, request_size, block_index
//  rsp     | out | valid/ready   | status, node_index, node_level, block_offset
//  cfg     | in  | cfg_wr_en     | cfg_index, cfg_wdata
//
// one word at a time; ready only while the sequencer is idle
// per word the sequencer scans nodes, writes the subtree and walks up or merges the levels;
// its pace is bound by the single busy bit memory
// after reset a clearing pass writes all 2**LEVEL_LIMIT-1 busy bits before the first word is taken
// a waiting result does not block the next request; a result is held while rsp is stalled
`default_nettype none
module buddy_bitmap_allocator_unit #(
    parameter int LEVEL_LIMIT = 10
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    bba_req_if.sink                                req,
    bba_rsp_if.source                              rsp,
    input  wire logic                              cfg_wr_en,
    input  wire logic [bba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bba_pkg::MBS_W-1:0]         cfg_wdata
);
    import bba_pkg::*;

    localparam int IDX_W = LEVEL_LIMIT;
    localparam int NW    = IDX_W + 1;
    localparam int DEPTH = (2 ** LEVEL_LIMIT) - 1;
    localparam int TOT_W = MBS_W + LEVEL_LIMIT - 1;
    localparam int CMP_W = ((TOT_W > TSIZE_W) ? TOT_W : TSIZE_W) + 1;
    localparam int CW    = (NW > BIDX_W) ? NW : BIDX_W;

    fsm_t                   state_reg, state_next;
    logic [LV_W-1:0]        tree_levels_reg;
    logic [MBS_W-1:0]       mbs_reg;
    cmd_t                   cmd_reg;
    logic [SIZE_W-1:0]      size_reg;
    logic [BIDX_W-1:0]      bidx_reg;
    logic [IDX_W-1:0]       cur_reg, cur_next;
    logic [IDX_W-1:0]       lo_reg, lo_next;
    logic [IDX_W-1:0]       hi_reg, hi_next;
    logic [IDX_W-1:0]       node_reg, node_next;
    logic [IDX_W-1:0]       hit_reg, hit_next;
    logic [IDX_W-1:0]       first_reg, first_next;
    logic [LV_W-1:0]        lvl_reg, lvl_next;
    logic                   val_reg, val_next;
    status_t                status_reg, status_next;
    logic                   out_valid_reg;
    logic [2:0]             out_status_reg;
    logic [BIDX_W-1:0]      out_idx_reg;
    logic [LV_W-1:0]        out_lvl_reg;
    logic [OFF_W-1:0]       out_off_reg;

    logic [LV_W-1:0]        lv;
    logic [NW-1:0]          nodes;
    logic [TOT_W-1:0]       total;
    logic [TSIZE_W-1:0]     tsize;
    logic                   mem_we, mem_wdata, mem_rdata;
    logic [IDX_W-1:0]       mem_waddr, mem_raddr;
    logic                   lvl_start;
    logic                   lvl_done;
    logic [LV_W-1:0]        lvl_level;
    logic [NW-1:0]          nlo;
    logic [IDX_W-1:0]       parent;
    logic [IDX_W-1:0]       buddy;
    logic                   load_out;
    logic                   ok;
    logic [IDX_W-1:0]       pos;
    logic [IDX_W-1:0]       scaled;
    logic [IDX_W+MBS_W-1:0] prod;

    assign lv    = (tree_levels_reg > LV_W'(LEVEL_LIMIT - 1)) ?
                   LV_W'(LEVEL_LIMIT - 1) : tree_levels_reg;
    assign nodes = (NW'(1) << (lv + LV_W'(1))) - NW'(1);
    assign total = TOT_W'(mbs_reg) << lv;
    assign tsize = TSIZE_W'(size_reg) + TSIZE_W'(HEADER_BYTES);
    assign nlo    = {lo_reg, 1'b1};
    assign parent = IDX_W'((node_reg - IDX_W'(1)) >> 1);
    assign buddy  = node_reg[0] ? (node_reg + IDX_W'(1)) : (node_reg - IDX_W'(1));

    bba_mem #(
        .DEPTH (DEPTH),
        .AW    (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bba_lvl #(
        .LEVEL_LIMIT (LEVEL_LIMIT)
    ) u_lvl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (lvl_start),
        .size_in (tsize),
        .total   (total),
        .cap     (lv),
        .done    (lvl_done),
        .level   (lvl_level)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tree_levels_reg <= LV_W'(4);
            mbs_reg         <= MBS_W'(16);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_TREE_LEVELS: tree_levels_reg <= cfg_wdata[LV_W-1:0];
                REG_MIN_BUCKET:  mbs_reg         <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= FSM_CLEAR;
            cur_reg    <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            node_reg   <= '0;
            hit_reg    <= '0;
            first_reg  <= '0;
            lvl_reg    <= '0;
            val_reg    <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            cur_reg    <= cur_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            node_reg   <= node_next;
            hit_reg    <= hit_next;
            first_reg  <= first_next;
            lvl_reg    <= lvl_next;
            val_reg    <= val_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            cmd_reg  <= cmd_t'(req.command);
            size_reg <= req.request_size;
            bidx_reg <= req.block_index;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        node_next     = node_reg;
        hit_next      = hit_reg;
        first_next    = first_reg;
        lvl_next      = lvl_reg;
        val_next      = val_reg;
        status_next   = status_reg;
        mem_we        = 1'b0;
        mem_waddr     = cur_reg;
        mem_wdata     = 1'b0;
        mem_raddr     = cur_reg;
        lvl_start     = 1'b0;
        req.ready     = 1'b0;
        load_out      = 1'b0;
        unique case (state_reg)
            FSM_CLEAR:
            begin
                mem_we = 1'b1;
                if (cur_reg == IDX_W'(DEPTH - 1))
                begin
                    state_next = FSM_IDLE;
                end
                else
                begin
                    cur_next = cur_reg + IDX_W'(1);
                end
            end
            FSM_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    state_next = FSM_CHECK;
                end
            end
            FSM_CHECK:
            begin
                status_next = ST_OK;
                if (cmd_reg == CMD_ALLOC)
                begin
                    if (size_reg[SIZE_W-1] || (size_reg == '0))
                    begin
                        status_next = ST_BAD_SIZE;
                        state_next  = FSM_DONE;
                    end
                    else if (CMP_W'(tsize) > CMP_W'(total))
                    begin
                        status_next = ST_TOO_LARGE;
                        state_next  = FSM_DONE;
                    end
                    else
                    begin
                        lvl_start  = 1'b1;
                        state_next = FSM_LEVEL;
                    end
                end
                else if (CW'(bidx_reg) >= CW'(nodes))
                begin
                    status_next = ST_BAD_INDEX;
                    state_next  = FSM_DONE;
                end
                else
                begin
                    mem_raddr  = IDX_W'(bidx_reg);
                    cur_next   = IDX_W'(bidx_reg);
                    state_next = FSM_FREE_CHK;
                end
            end
            FSM_LEVEL:
            begin
                if (lvl_done)
                begin
                    lvl_next   = lvl_level;
                    first_next = (IDX_W'(1) << lvl_level) - IDX_W'(1);
                    cur_next   = (IDX_W'(1) << lvl_level) - IDX_W'(1);
                    state_next = FSM_SCAN_RD;
                end
            end
            FSM_SCAN_RD:
            begin
                state_next = FSM_SCAN_CHK;
            end
            FSM_SCAN_CHK:
            begin
                if (!mem_rdata)
                begin
                    hit_next   = cur_reg;
                    node_next  = cur_reg;
                    lo_next    = cur_reg;
                    hi_next    = cur_reg;
                    val_next   = 1'b1;
                    state_next = FSM_SUB;
                end
                else if (cur_reg == {first_reg[IDX_W-2:0], 1'b0})
                begin
                    status_next = ST_NO_BLOCK;
                    state_next  = FSM_DONE;
                end
                else
                begin
                    cur_next   = cur_reg + IDX_W'(1);
                    state_next = FSM_SCAN_RD;
                end
            end
            FSM_FREE_CHK:
            begin
                if (!mem_rdata)
                begin
                    status_next = ST_DOUBLE_FREE;
                    state_next  = FSM_DONE;
                end
                else
                begin
                    node_next  = cur_reg;
                    lo_next    = cur_reg;
                    hi_next    = cur_reg;
                    val_next   = 1'b0;
                    state_next = FSM_SUB;
                end
            end
            FSM_SUB:
            begin
                mem_we    = 1'b1;
                mem_wdata = val_reg;
                if (cur_reg != hi_reg)
                begin
                    cur_next = cur_reg + IDX_W'(1);
                end
                else if (nlo < nodes)
                begin
                    lo_next  = IDX_W'(nlo);
                    cur_next = IDX_W'(nlo);
                    hi_next  = IDX_W'({hi_reg, 1'b0} + NW'(2));
                end
                else if (node_reg == '0)
                begin
                    state_next = FSM_DONE;
                end
                else if (cmd_reg == CMD_ALLOC)
                begin
                    state_next = FSM_UP;
                end
                else
                begin
                    state_next = FSM_MERGE_RD;
                end
            end
            FSM_UP:
            begin
                mem_we    = 1'b1;
                mem_waddr = parent;
                mem_wdata = 1'b1;
                node_next = parent;
                if (parent == '0)
                begin
                    state_next = FSM_DONE;
                end
            end
            FSM_MERGE_RD:
            begin
                mem_raddr  = buddy;
                state_next = FSM_MERGE_CHK;
            end
            FSM_MERGE_CHK:
            begin
                if (mem_rdata)
                begin
                    state_next = FSM_DONE;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = parent;
                    mem_wdata = 1'b0;
                    node_next = parent;
                    state_next = (parent == '0) ? FSM_DONE : FSM_MERGE_RD;
                end
            end
            FSM_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    assign ok     = (status_reg == ST_OK) && (cmd_reg == CMD_ALLOC);
    assign pos    = hit_reg - first_reg;
    assign scaled = pos << (lv - lvl_reg);
    assign prod   = (IDX_W + MBS_W)'(scaled) * (IDX_W + MBS_W)'(mbs_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg <= status_reg;
            out_idx_reg    <= ok ? BIDX_W'(hit_reg) : '0;
            out_lvl_reg    <= ok ? lvl_reg : '0;
            out_off_reg    <= ok ? OFF_W'(prod) : '0;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.node_index   = out_idx_reg;
    assign rsp.node_level   = out_lvl_reg;
    assign rsp.block_offset = out_off_reg;
endmodule
`default_nettype wire

### sv/bba_mem.sv
// busy bit memory, one write and one registered read port
`default_nettype none
module bba_mem #(
    parameter int DEPTH = 1023,
    parameter int AW    = 10
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic          wdata,
    input  wire logic [AW-1:0] raddr,
    output logic               rdata
);
    logic mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### sv/bba_lvl.sv
// iterative shift and compare unit finding the allocation level
`default_nettype none
module bba_lvl #(
    parameter int LEVEL_LIMIT = 10
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [bba_pkg::TSIZE_W-1:0]     size_in,
    input  wire logic [bba_pkg::MBS_W+LEVEL_LIMIT-2:0] total,
    input  wire logic [bba_pkg::LV_W-1:0]        cap,
    output logic                                 done,
    output logic [bba_pkg::LV_W-1:0]             level
);
    import bba_pkg::*;

    localparam int TOT_W = MBS_W + LEVEL_LIMIT - 1;
    localparam int CMP_W = ((TOT_W > TSIZE_W) ? TOT_W : TSIZE_W) + 1;

    logic             run_reg;
    logic [CMP_W-1:0] sh_reg;
    logic [LV_W-1:0]  k_reg;
    logic [CMP_W-1:0] dbl;
    logic             grow;

    assign dbl  = {sh_reg[CMP_W-2:0], 1'b0};
    assign grow = (k_reg < cap) && (dbl <= CMP_W'(total));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            k_reg   <= '0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
            k_reg   <= '0;
        end
        else if (run_reg)
        begin
            if (grow)
            begin
                k_reg <= k_reg + LV_W'(1);
            end
            else
            begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg <= CMP_W'(size_in);
        end
        else if (run_reg && grow)
        begin
            sh_reg <= dbl;
        end
    end

    assign done  = run_reg && !grow;
    assign level = k_reg;
endmodule
`default_nettype wire

### sv/bba_chk.sv
// port level checks of the buddy bitmap allocator and their binding
`default_nettype none
module bba_chk (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          req_valid,
    input wire logic                          req_ready,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic [2:0]                    status,
    input wire logic [bba_pkg::BIDX_W-1:0]    node_index,
    input wire logic [bba_pkg::LV_W-1:0]      node_level,
    input wire logic [bba_pkg::OFF_W-1:0]     block_offset
);
    import bba_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(block_offset))
        else $error("stalled response word changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ST_OK) |-> (node_index == '0) && (node_level == '0)
        && (block_offset == '0))
        else $error("failed request carries a grant");

    a_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (node_level == '0) |-> (node_index == '0) && (block_offset == '0))
        else $error("root grant with non-zero index or offset");
endmodule

bind buddy_bitmap_allocator_unit bba_chk u_bba_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .status       (rsp.status),
    .node_index   (rsp.node_index),
    .node_level   (rsp.node_level),
    .block_offset (rsp.block_offset)
);
`default_nettype wire
